// ===== src/sfr_pkg.sv =====
// sfr_pkg: shared types, codes and the field layout table for the sensor frame receiver
// no dependencies

package sfr_pkg;

  // width of a field number and the number of the last field in one frame
  localparam int FIELD_IDX_W = 6;
  localparam logic [FIELD_IDX_W-1:0] LAST_FIELD = 6'd34;

  // byte offset of a field inside the frame
  localparam int OFFSET_W = 7;

  // configuration register indexes
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_HEADER_FIRST  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_HEADER_SECOND = 1'b1;

  // register reset values
  localparam logic [7:0] HEADER_FIRST_RESET  = 8'h55;
  localparam logic [7:0] HEADER_SECOND_RESET = 8'h01;

  // field kinds
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_U8  = 3'd0;
  localparam kind_t KIND_S24 = 3'd1;
  localparam kind_t KIND_W32 = 3'd2;
  localparam kind_t KIND_S16 = 3'd3;
  localparam kind_t KIND_U16 = 3'd4;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    kind_t               kind;
  } field_desc_t;

  // frame layout, one entry per field in frame order
  function automatic field_desc_t field_desc(input logic [FIELD_IDX_W-1:0] idx);
    field_desc_t d;
    d = '{offset: 7'd0, kind: KIND_U8};
    case (idx)
      6'd0:  d = '{offset: 7'd2,   kind: KIND_U8};
      6'd1:  d = '{offset: 7'd3,   kind: KIND_U8};
      6'd2:  d = '{offset: 7'd4,   kind: KIND_S24};
      6'd3:  d = '{offset: 7'd7,   kind: KIND_S24};
      6'd4:  d = '{offset: 7'd10,  kind: KIND_S24};
      6'd5:  d = '{offset: 7'd13,  kind: KIND_S24};
      6'd6:  d = '{offset: 7'd16,  kind: KIND_S24};
      6'd7:  d = '{offset: 7'd19,  kind: KIND_S24};
      6'd8:  d = '{offset: 7'd22,  kind: KIND_S24};
      6'd9:  d = '{offset: 7'd25,  kind: KIND_S24};
      6'd10: d = '{offset: 7'd28,  kind: KIND_S24};
      6'd11: d = '{offset: 7'd31,  kind: KIND_S24};
      6'd12: d = '{offset: 7'd34,  kind: KIND_S24};
      6'd13: d = '{offset: 7'd37,  kind: KIND_S24};
      6'd14: d = '{offset: 7'd40,  kind: KIND_S24};
      6'd15: d = '{offset: 7'd43,  kind: KIND_S24};
      6'd16: d = '{offset: 7'd46,  kind: KIND_W32};
      6'd17: d = '{offset: 7'd50,  kind: KIND_W32};
      6'd18: d = '{offset: 7'd54,  kind: KIND_W32};
      6'd19: d = '{offset: 7'd58,  kind: KIND_W32};
      6'd20: d = '{offset: 7'd62,  kind: KIND_W32};
      6'd21: d = '{offset: 7'd66,  kind: KIND_W32};
      6'd22: d = '{offset: 7'd82,  kind: KIND_S16};
      6'd23: d = '{offset: 7'd84,  kind: KIND_S16};
      6'd24: d = '{offset: 7'd86,  kind: KIND_S16};
      6'd25: d = '{offset: 7'd88,  kind: KIND_W32};
      6'd26: d = '{offset: 7'd92,  kind: KIND_W32};
      6'd27: d = '{offset: 7'd96,  kind: KIND_W32};
      6'd28: d = '{offset: 7'd100, kind: KIND_W32};
      6'd29: d = '{offset: 7'd108, kind: KIND_W32};
      6'd30: d = '{offset: 7'd112, kind: KIND_W32};
      6'd31: d = '{offset: 7'd117, kind: KIND_U8};
      6'd32: d = '{offset: 7'd118, kind: KIND_U8};
      6'd33: d = '{offset: 7'd119, kind: KIND_U8};
      6'd34: d = '{offset: 7'd120, kind: KIND_U16};
      default: d = '{offset: 7'd0, kind: KIND_U8};
    endcase
    return d;
  endfunction

  // index of the last byte of a field of the given kind
  function automatic logic [1:0] kind_last_byte(input kind_t kind);
    logic [1:0] n;
    n = 2'd0;
    case (kind) inside
      KIND_S24:            n = 2'd2;
      KIND_W32:            n = 2'd3;
      KIND_S16, KIND_U16:  n = 2'd1;
      default:             n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== src/sensor_frame_receiver_core.sv =====
// sensor_frame_receiver_core: frame hunt, checksum and field decoder for a serial sensor link
// depends on sfr_pkg (field layout, kinds, register indexes)

// The core takes one received byte per input transaction and hunts for the
// two header bytes (header_first then header_second, written through the cfg
// port). After the header it stores the rest of a FRAME_BYTES frame in an
// on-chip byte memory while keeping an 8-bit wrapping sum of every byte but
// the last, which is the checksum. While hunting or collecting, a byte is
// taken every cycle. On a checksum mismatch one result goes out with status 1,
// field_index 0, field_value 0 and field_last 1. On a match the 35 fields are
// read back from the memory one byte at a time through its single registered
// read port and assembled little-endian, signed kinds sign-extended to 32
// bits: each byte passes through a fetch state (address) and a load state
// (data), then each field goes out as its own output transaction. Input is
// stalled for the whole burst. Values are raw: positions and distances in
// milli-units, velocities in tenth-milli-units and angles in centi-units;
// float fields are passed as their bit patterns. There is no clearing pass:
// every byte that is decoded is written earlier in the same frame.

module sensor_frame_receiver_core #(
  parameter int FRAME_BYTES = 128  // 123 to 256
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [sfr_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                         cfg_data,
  // received byte transactions
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         rx_byte,
  // decoded field transactions
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               status,
  output logic [sfr_pkg::FIELD_IDX_W-1:0]    field_index,
  output logic [31:0]                        field_value,
  output logic                               field_last
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam logic [AW:0]   LAST_BODY = (AW+1)'(FRAME_BYTES - 1);
  localparam logic [AW-1:0] CHECK_POS = AW'(FRAME_BYTES - 1);
  localparam logic [AW-1:0] FIRST_BODY_POS = AW'(2);

  // sequencer states
  localparam logic [2:0] S_HUNT   = 3'd0;  // waiting for header_first
  localparam logic [2:0] S_SECOND = 3'd1;  // waiting for header_second
  localparam logic [2:0] S_BODY   = 3'd2;  // collecting frame bytes
  localparam logic [2:0] S_CHECK  = 3'd3;  // next byte is the checksum
  localparam logic [2:0] S_FETCH  = 3'd4;  // issue a memory read
  localparam logic [2:0] S_LOAD   = 3'd5;  // merge read byte into the field
  localparam logic [2:0] S_SEND   = 3'd6;  // result on the output

  logic [2:0]    state;
  logic [7:0]    header_first;
  logic [7:0]    header_second;
  logic [AW-1:0] byte_count;
  logic [7:0]    running_sum;
  logic [sfr_pkg::FIELD_IDX_W-1:0] emit_index;
  logic [1:0]    byte_sel;
  logic [31:0]   acc;

  // frame memory, one write and one registered read per cycle
  logic [7:0]    frame_store [FRAME_BYTES];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  logic          in_fire;
  logic          out_fire;
  logic [AW:0]   count_inc;
  logic [31:0]   acc_next;
  logic [31:0]   value_ext;
  logic [1:0]    last_byte;
  sfr_pkg::field_desc_t desc;

  // input side is open only while hunting or collecting
  assign in_stall  = !(state == S_HUNT || state == S_SECOND ||
                       state == S_BODY || state == S_CHECK);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = (state == S_SEND);
  assign out_fire  = out_valid && !out_stall;

  assign count_inc = {1'b0, byte_count} + (AW+1)'(1);

  // layout of the field being decoded
  assign desc      = sfr_pkg::field_desc(emit_index);
  assign last_byte = sfr_pkg::kind_last_byte(desc.kind);
  assign mem_raddr = AW'(desc.offset) + AW'(byte_sel);

  // store the header, body and checksum bytes at their frame positions
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = byte_count;
    unique case (state)
      S_HUNT: begin
        mem_we    = in_fire && (rx_byte == header_first);
        mem_waddr = '0;
      end
      S_SECOND: begin
        mem_we    = in_fire && (rx_byte == header_second);
        mem_waddr = AW'(1);
      end
      S_BODY: begin
        mem_we    = in_fire;
        mem_waddr = byte_count;
      end
      S_CHECK: begin
        mem_we    = in_fire;
        mem_waddr = CHECK_POS;
      end
      default: begin
        mem_we    = 1'b0;
        mem_waddr = byte_count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[mem_waddr] <= rx_byte;
    end
    mem_rdata <= frame_store[mem_raddr];
  end

  // little-endian byte merge and extension by kind
  always_comb begin
    acc_next = acc;
    case (byte_sel)
      2'd0:    acc_next[7:0]   = mem_rdata;
      2'd1:    acc_next[15:8]  = mem_rdata;
      2'd2:    acc_next[23:16] = mem_rdata;
      default: acc_next[31:24] = mem_rdata;
    endcase
  end

  always_comb begin
    case (desc.kind)
      sfr_pkg::KIND_S24: value_ext = {{8{acc_next[23]}}, acc_next[23:0]};
      sfr_pkg::KIND_S16: value_ext = {{16{acc_next[15]}}, acc_next[15:0]};
      sfr_pkg::KIND_U16: value_ext = {16'd0, acc_next[15:0]};
      sfr_pkg::KIND_W32: value_ext = acc_next;
      default:           value_ext = {24'd0, acc_next[7:0]};
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= sfr_pkg::HEADER_FIRST_RESET;
      header_second <= sfr_pkg::HEADER_SECOND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfr_pkg::REG_HEADER_FIRST:  header_first  <= cfg_data;
        sfr_pkg::REG_HEADER_SECOND: header_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_HUNT;
      byte_count  <= '0;
      running_sum <= '0;
      emit_index  <= '0;
      byte_sel    <= '0;
    end else begin
      unique case (state)
        S_HUNT: begin
          if (in_fire && rx_byte == header_first) begin
            running_sum <= rx_byte;
            state       <= S_SECOND;
          end
        end
        S_SECOND: begin
          if (in_fire) begin
            // a wrong second byte restarts the hunt, it is not retried
            if (rx_byte == header_second) begin
              running_sum <= running_sum + rx_byte;
              byte_count  <= FIRST_BODY_POS;
              state       <= S_BODY;
            end else begin
              state <= S_HUNT;
            end
          end
        end
        S_BODY: begin
          if (in_fire) begin
            running_sum <= running_sum + rx_byte;
            byte_count  <= count_inc[AW-1:0];
            if (count_inc >= LAST_BODY) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (in_fire) begin
            byte_count <= '0;
            emit_index <= '0;
            byte_sel   <= '0;
            if (rx_byte != running_sum) begin
              state <= S_SEND;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (byte_sel == last_byte) begin
            state <= S_SEND;
          end else begin
            byte_sel <= byte_sel + 2'd1;
            state    <= S_FETCH;
          end
        end
        S_SEND: begin
          if (out_fire) begin
            if (field_last) begin
              emit_index <= '0;
              state      <= S_HUNT;
            end else begin
              emit_index <= emit_index + 1'b1;
              byte_sel   <= '0;
              state      <= S_FETCH;
            end
          end
        end
        default: begin
          state <= S_HUNT;
        end
      endcase
    end
  end

  // field accumulator and output register
  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      acc <= acc_next;
    end
    if (state == S_CHECK && in_fire && rx_byte != running_sum) begin
      // checksum mismatch, single error transaction
      status      <= 1'b1;
      field_index <= '0;
      field_value <= '0;
      field_last  <= 1'b1;
    end else if (state == S_LOAD && byte_sel == last_byte) begin
      status      <= 1'b0;
      field_index <= emit_index;
      field_value <= value_ext;
      field_last  <= (emit_index == sfr_pkg::LAST_FIELD);
    end
  end

endmodule
